@@ design/bcb_pkg.sv @@
// ----------------------------------------------------------------------------
// bcb_pkg
// shared types and constants of the border collar blanker
// ----------------------------------------------------------------------------
package bcb_pkg;

    localparam int NUM_BANDS = 4;

    // register indexes of the configuration port
    localparam logic [2:0] REG_NEAR_DIST     = 3'd0;
    localparam logic [2:0] REG_MAX_NON_BLACK = 3'd1;
    localparam logic [2:0] REG_NEAR_WHITE    = 3'd2;
    localparam logic [2:0] REG_BAND_COUNT    = 3'd3;
    localparam logic [2:0] REG_ALPHA_PRESENT = 3'd4;

    // reset values of the configuration registers
    localparam logic [7:0] RST_NEAR_DIST     = 8'd15;
    localparam logic [7:0] RST_MAX_NON_BLACK = 8'd2;
    localparam logic [2:0] RST_BAND_COUNT    = 3'd3;

    // item function codes
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_EMIT = 1'b1;

    typedef struct packed {
        logic [7:0]                      alpha;
        logic [NUM_BANDS-1:0][7:0]       band;
    } t_pixel;

    typedef struct packed {
        logic [7:0] near_dist;
        logic [7:0] max_non_black;
        logic       near_white;
        logic [2:0] band_count;
        logic       alpha_present;
    } t_cfg;

    // one queued operation, column index travels beside it
    typedef struct packed {
        logic   is_load;
        t_pixel pix;
        logic   first_row;
        logic   do_vert;
        logic   do_horiz;
        logic   last;
    } t_op;

endpackage

@@ design/bcb_if.sv @@
// ----------------------------------------------------------------------------
// bcb_if
// handshake channels of the border collar blanker: pixel in, pixel out, config
// ----------------------------------------------------------------------------
interface bcb_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] pixel_band0;
    logic [7:0] pixel_band1;
    logic [7:0] pixel_band2;
    logic [7:0] pixel_band3;
    logic [7:0] alpha_in;
    logic       first_row_of_pass;
    logic       do_vertical;
    logic       do_horizontal;
    logic       last_in_line;

    modport source (
        output valid, func, pixel_band0, pixel_band1, pixel_band2, pixel_band3,
               alpha_in, first_row_of_pass, do_vertical, do_horizontal, last_in_line,
        input  ready
    );
    modport sink (
        input  valid, func, pixel_band0, pixel_band1, pixel_band2, pixel_band3,
               alpha_in, first_row_of_pass, do_vertical, do_horizontal, last_in_line,
        output ready
    );
endinterface

interface bcb_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] column;
    logic [7:0]  out_band0;
    logic [7:0]  out_band1;
    logic [7:0]  out_band2;
    logic [7:0]  out_band3;
    logic [7:0]  out_alpha;
    logic        line_done;

    modport source (
        output valid, column, out_band0, out_band1, out_band2, out_band3,
               out_alpha, line_done,
        input  ready
    );
    modport sink (
        input  valid, column, out_band0, out_band1, out_band2, out_band3,
               out_alpha, line_done,
        output ready
    );
endinterface

interface bcb_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] index;
    logic [7:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ design/bcb_front.sv @@
// ----------------------------------------------------------------------------
// bcb_front
// accepts beats, tracks load and emit columns, queues the work
// ----------------------------------------------------------------------------
module bcb_front #(
    parameter int MAX_WIDTH = 4096,
    parameter int COL_W     = 12
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    bcb_in_if.sink             i_pix,
    input  logic               i_q_full,
    output logic               o_q_push,
    output bcb_pkg::t_op       o_q_op,
    output logic [COL_W-1:0]   o_q_col
);
    import bcb_pkg::*;

    localparam int ECNT_W = $clog2(MAX_WIDTH + 1);

    logic [COL_W-1:0]  r_load_col, n_load_col;
    logic [ECNT_W-1:0] r_emit_col, n_emit_col;
    logic              accept;
    logic              last;

    assign i_pix.ready = !i_q_full;
    assign accept      = i_pix.valid && i_pix.ready;

    // a load into the final column closes the line anyway
    assign last = i_pix.last_in_line || (r_load_col == COL_W'(MAX_WIDTH - 1));

    always_comb begin
        n_load_col = r_load_col;
        n_emit_col = r_emit_col;
        o_q_push   = 1'b0;
        o_q_col    = r_load_col;

        o_q_op.is_load        = (i_pix.func == FUNC_LOAD);
        o_q_op.pix.band[0]    = i_pix.pixel_band0;
        o_q_op.pix.band[1]    = i_pix.pixel_band1;
        o_q_op.pix.band[2]    = i_pix.pixel_band2;
        o_q_op.pix.band[3]    = i_pix.pixel_band3;
        o_q_op.pix.alpha      = i_pix.alpha_in;
        o_q_op.first_row      = i_pix.first_row_of_pass;
        o_q_op.do_vert        = i_pix.do_vertical;
        o_q_op.do_horiz       = i_pix.do_horizontal;
        o_q_op.last           = last;

        if (i_pix.func == FUNC_LOAD) begin
            o_q_push = accept;
            if (accept) begin
                if (last) begin
                    n_load_col = '0;
                    n_emit_col = ECNT_W'(r_load_col) + ECNT_W'(1);
                end else begin
                    n_load_col = r_load_col + COL_W'(1);
                end
            end
        end else begin
            // emit with nothing pending is dropped here
            o_q_col  = COL_W'(r_emit_col - ECNT_W'(1));
            o_q_push = accept && (r_emit_col != '0);
            if (o_q_push) begin
                n_emit_col = r_emit_col - ECNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_col <= '0;
            r_emit_col <= '0;
        end else begin
            r_load_col <= n_load_col;
            r_emit_col <= n_emit_col;
        end
    end

endmodule

@@ design/bcb_queue.sv @@
// ----------------------------------------------------------------------------
// bcb_queue
// short first-in first-out queue between the front and back ends
// ----------------------------------------------------------------------------
module bcb_queue #(
    parameter int COL_W = 12,
    parameter int DEPTH = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  bcb_pkg::t_op       i_op,
    input  logic [COL_W-1:0]   i_col,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_empty,
    output bcb_pkg::t_op       o_op,
    output logic [COL_W-1:0]   o_col
);
    import bcb_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_op              mem_op  [DEPTH];
    logic [COL_W-1:0] mem_col [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_op    = mem_op[r_rd_ptr];
    assign o_col   = mem_col[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            mem_op[r_wr_ptr]  <= i_op;
            mem_col[r_wr_ptr] <= i_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            r_count <= r_count + CNT_W'(do_push) - CNT_W'(do_pop);
        end
    end

endmodule

@@ design/bcb_back.sv @@
// ----------------------------------------------------------------------------
// bcb_back
// reads line and column memories, runs the border checks, drives results
// ----------------------------------------------------------------------------
module bcb_back #(
    parameter int MAX_WIDTH = 4096,
    parameter int COL_W     = 12
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bcb_pkg::t_cfg      i_cfg,
    input  logic               i_q_empty,
    input  bcb_pkg::t_op       i_q_op,
    input  logic [COL_W-1:0]   i_q_col,
    output logic               o_q_pop,
    bcb_out_if.source          o_pix
);
    import bcb_pkg::*;

    typedef enum logic {S_READ, S_EXEC} t_state;

    t_pixel           mem_line [MAX_WIDTH];
    logic [7:0]       mem_cnt  [MAX_WIDTH];

    t_state           r_state;
    t_op              r_op;
    logic [COL_W-1:0] r_col;
    t_pixel           r_line_rd;
    logic [7:0]       r_cnt_rd;
    logic [7:0]       r_run_count, n_run_count;
    logic             r_run_stopped, n_run_stopped;
    logic             r_out_valid;
    logic [11:0]      r_out_col;
    t_pixel           r_out_px;
    logic             r_line_done;

    logic             go;
    logic             line_we, cnt_we;
    t_pixel           px_src, px_v, px_h, px_out;
    logic [7:0]       cnt0, cnt_new;
    logic             nb, nb_h, vblank, hblank, apply_h;
    logic [7:0]       rc, rc_inc;
    logic             rs;
    logic [31:0]      col_ext;

    function automatic logic [7:0] sat_inc(input logic [7:0] c);
        return (c == 8'hFF) ? c : c + 8'd1;
    endfunction

    function automatic logic [2:0] bands_used(input t_cfg cfg);
        return (cfg.band_count > 3'(NUM_BANDS)) ? 3'(NUM_BANDS) : cfg.band_count;
    endfunction

    function automatic logic non_border(input t_pixel px, input t_cfg cfg);
        logic       hit;
        logic [7:0] d;
        hit = 1'b0;
        for (int b = 0; b < NUM_BANDS; b++) begin
            d = cfg.near_white ? ~px.band[b] : px.band[b];
            if ((3'(b) < bands_used(cfg)) && (d > cfg.near_dist)) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic t_pixel blank(input t_pixel px, input t_cfg cfg);
        t_pixel p;
        p = px;
        for (int b = 0; b < NUM_BANDS; b++) begin
            if (3'(b) < bands_used(cfg)) begin
                p.band[b] = cfg.near_white ? 8'hFF : 8'h00;
            end
        end
        if (cfg.alpha_present) begin
            p.alpha = 8'h00;
        end
        return p;
    endfunction

    assign o_q_pop = (r_state == S_READ) && !i_q_empty;

    // an emit waits until the result register is free or its result is taken
    assign go = (r_state == S_EXEC) && (r_op.is_load || !r_out_valid || o_pix.ready);

    always_comb begin
        px_src  = r_op.is_load ? r_op.pix : r_line_rd;
        nb      = non_border(px_src, i_cfg);

        // vertical check, loads only
        cnt0    = r_op.first_row ? 8'd0 : r_cnt_rd;
        cnt_new = cnt0;
        vblank  = 1'b0;
        if (cnt0 <= i_cfg.max_non_black) begin
            if (nb) begin
                cnt_new = sat_inc(cnt0);
                vblank  = (cnt_new <= i_cfg.max_non_black);
            end else begin
                cnt_new = 8'd0;
                vblank  = 1'b1;
            end
        end
        vblank = vblank && r_op.is_load && r_op.do_vert;
        px_v   = vblank ? blank(px_src, i_cfg) : px_src;
        nb_h   = vblank ? 1'b0 : nb;

        // run check, restarted on a load into column zero
        rc = (r_op.is_load && (r_col == '0)) ? 8'd0 : r_run_count;
        rs = (r_op.is_load && (r_col == '0)) ? 1'b0 : r_run_stopped;
        apply_h = r_op.do_horiz && (r_op.is_load ? !r_op.last : (r_col != '0));
        rc_inc  = sat_inc(rc);
        n_run_count   = rc;
        n_run_stopped = rs;
        hblank        = 1'b0;
        if (apply_h && !rs) begin
            if (nb_h) begin
                n_run_count = rc_inc;
                if (rc_inc > i_cfg.max_non_black) begin
                    n_run_stopped = 1'b1;
                end else begin
                    hblank = 1'b1;
                end
            end else begin
                n_run_count = 8'd0;
                hblank      = 1'b1;
            end
        end
        if (r_op.is_load && r_op.last) begin
            n_run_count   = 8'd0;
            n_run_stopped = 1'b0;
        end
        px_h = hblank ? blank(px_v, i_cfg) : px_v;

        // alpha only travels out when present
        px_out = px_h;
        if (!i_cfg.alpha_present) begin
            px_out.alpha = 8'h00;
        end

        line_we = go && (r_op.is_load || hblank);
        cnt_we  = go && r_op.is_load && r_op.do_vert;
        col_ext = 32'(r_col);
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_line_rd <= mem_line[i_q_col];
            r_cnt_rd  <= mem_cnt[i_q_col];
        end
        if (line_we) begin
            mem_line[r_col] <= px_h;
        end
        if (cnt_we) begin
            mem_cnt[r_col] <= cnt_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_READ;
            r_run_count   <= '0;
            r_run_stopped <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            // a new result may replace the one taken in the same cycle
            if (go && !r_op.is_load) begin
                r_out_valid <= 1'b1;
            end else if (o_pix.valid && o_pix.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_READ: begin
                    if (o_q_pop) begin
                        r_op    <= i_q_op;
                        r_col   <= i_q_col;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (go) begin
                        r_run_count   <= n_run_count;
                        r_run_stopped <= n_run_stopped;
                        if (!r_op.is_load) begin
                            r_out_col   <= col_ext[11:0];
                            r_out_px    <= px_out;
                            r_line_done <= (r_col == '0);
                        end
                        r_state <= S_READ;
                    end
                end
                default: r_state <= S_READ;
            endcase
        end
    end

    assign o_pix.valid     = r_out_valid;
    assign o_pix.column    = r_out_col;
    assign o_pix.out_band0 = r_out_px.band[0];
    assign o_pix.out_band1 = r_out_px.band[1];
    assign o_pix.out_band2 = r_out_px.band[2];
    assign o_pix.out_band3 = r_out_px.band[3];
    assign o_pix.out_alpha = r_out_px.alpha;
    assign o_pix.line_done = r_line_done;

endmodule

@@ design/border_collar_blanker.sv @@
// ----------------------------------------------------------------------------
// border_collar_blanker
// forces a nearly black or nearly white image border to exact black or white
// ----------------------------------------------------------------------------
// Pixels of a line are loaded left to right (func 0) and emitted right to left
// (func 1). A load runs the per-column vertical check and the left-to-right run
// check and stores the pixel in the line memory; an emit reads it back, runs
// the right-to-left run check and returns one result beat. The front end takes
// one beat a cycle while the queue is not full into a two-entry queue; the back
// end does a registered read of the line and column memories per queued item,
// then the checks and the write back, and takes a new item only when done with
// the last. An emit with no line pending is accepted and gives no result. The
// memories have no reset: after reset, loads must start with first_row_of_pass
// set for each column before its counter is read. Configuration must be
// written only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module border_collar_blanker #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bcb_cfg_if.sink     i_cfg,
    bcb_in_if.sink      i_pix,
    bcb_out_if.source   o_pix
);
    import bcb_pkg::*;

    // column index width of the line memory
    localparam int COL_W = $clog2(MAX_WIDTH);

    t_cfg             r_cfg;
    logic             q_push, q_pop, q_full, q_empty;
    t_op              q_in_op, q_out_op;
    logic [COL_W-1:0] q_in_col, q_out_col;

    // configuration registers, always ready
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.near_dist     <= RST_NEAR_DIST;
            r_cfg.max_non_black <= RST_MAX_NON_BLACK;
            r_cfg.near_white    <= 1'b0;
            r_cfg.band_count    <= RST_BAND_COUNT;
            r_cfg.alpha_present <= 1'b0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_NEAR_DIST:     r_cfg.near_dist     <= i_cfg.data;
                REG_MAX_NON_BLACK: r_cfg.max_non_black <= i_cfg.data;
                REG_NEAR_WHITE:    r_cfg.near_white    <= i_cfg.data[0];
                REG_BAND_COUNT:    r_cfg.band_count    <= i_cfg.data[2:0];
                REG_ALPHA_PRESENT: r_cfg.alpha_present <= i_cfg.data[0];
                default: begin
                    // writes beyond the register list are ignored
                end
            endcase
        end
    end

    // front end: column bookkeeping, one beat per cycle while the queue is not full
    bcb_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .COL_W     (COL_W)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_pix    (i_pix),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_op   (q_in_op),
        .o_q_col  (q_in_col)
    );

    // decoupling queue between front and back end
    bcb_queue #(
        .COL_W (COL_W),
        .DEPTH (2)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_op    (q_in_op),
        .i_col   (q_in_col),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_op    (q_out_op),
        .o_col   (q_out_col)
    );

    // back end: memories, vertical and run checks, result register
    bcb_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .COL_W     (COL_W)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_empty (q_empty),
        .i_q_op    (q_out_op),
        .i_q_col   (q_out_col),
        .o_q_pop   (q_pop),
        .o_pix     (o_pix)
    );

endmodule
